// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Clocked check, disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DZV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define DZV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dzv_pkg.sv
package dzv_pkg;

    // Fixed field widths of the ports.
    localparam int CHANNEL_W   = 4;
    localparam int SAMPLE_IN_W = 32;
    localparam int BYTE_W      = 8;

    // ZigZag code is held to 35 bits: five LEB128 digits of 7 bits.
    localparam int DIGIT_BITS = 7;
    localparam int CODE_BITS  = 35;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

// File: rtl/delta_zigzag_varint_encoder.sv
// Channel  | Direction | Word                                      | Handshake
// s_       | in        | channel, sample_centi, restart_chunk      | s_valid / s_ready
// m_       | out       | code_byte, last_byte (one LEB128 byte)    | m_valid / m_ready
//
// A sample whose code takes n bytes (1..5) passes through ST_CALC for the delta subtract and
// ZigZag map, then ST_EMIT for each byte out of the 7-bit digit shifter.
// A new sample is taken on the same edge that hands off the last byte of the previous one.
// A sample on a channel at or above CHANNELS is taken but produces no bytes.
// Reset clears all has-previous marks at once; stored previous values need no reset.
// A stall on m_ready holds the current byte; s_ready stays low until the last byte goes.
module delta_zigzag_varint_encoder #(
    parameter int CHANNELS    = 15,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dzv_pkg::CHANNEL_W-1:0]         s_channel,
    input  logic signed [dzv_pkg::SAMPLE_IN_W-1:0] s_sample_centi,
    input  logic                                  s_restart_chunk,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dzv_pkg::BYTE_W-1:0]            m_code_byte,
    output logic                                  m_last_byte
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W   = (IDX_W > dzv_pkg::CHANNEL_W) ? IDX_W : dzv_pkg::CHANNEL_W;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CODE_W = dzv_pkg::CODE_BITS;
    localparam int DIG_W  = dzv_pkg::DIGIT_BITS;
    localparam int IN_W   = dzv_pkg::SAMPLE_IN_W;

    dzv_pkg::state_t state_reg, state_next;

    logic                          s_accept;
    logic [CH_W-1:0]               ch_wide;
    logic [IDX_W-1:0]              ch_addr;
    logic                          ch_in_range;
    logic signed [SAMPLE_BITS-1:0] sample_sat;

    // Per-channel history: values in a small memory, marks in flip-flops.
    logic signed [SAMPLE_BITS-1:0] prev_mem [CHANNELS];
    logic [CHANNELS-1:0]           mark_reg, mark_next;
    logic [CHANNELS-1:0]           marks_kept;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                          first_reg;

    logic signed [DIFF_W-1:0]      diff;
    logic signed [CODE_W-1:0]      code_sat;
    logic [CODE_W-1:0]             zigzag;
    logic [CODE_W-1:0]             rest_reg, rest_next;
    logic                          more_bytes;

    // Accept a new word when idle, or on the edge that hands off the last byte.
    assign s_ready  = (state_reg == dzv_pkg::ST_IDLE) ||
                      ((state_reg == dzv_pkg::ST_EMIT) && !more_bytes && m_ready);
    assign s_accept = s_valid && s_ready;

    assign ch_wide     = CH_W'(s_channel);
    assign ch_addr     = ch_wide[IDX_W-1:0];
    assign ch_in_range = ({1'b0, ch_wide} < (CH_W + 1)'(CHANNELS));

    // Saturate the input to the stored sample width when that is narrower.
    generate
        if (SAMPLE_BITS < IN_W) begin : g_sat_in
            logic fits;
            assign fits = (&s_sample_centi[IN_W-1:SAMPLE_BITS-1]) ||
                          !(|s_sample_centi[IN_W-1:SAMPLE_BITS-1]);
            assign sample_sat = fits ? s_sample_centi[SAMPLE_BITS-1:0] :
                {s_sample_centi[IN_W-1], {(SAMPLE_BITS - 1){!s_sample_centi[IN_W-1]}}};
        end else begin : g_ext_in
            assign sample_sat = SAMPLE_BITS'(s_sample_centi);
        end
    endgenerate

    // Restart drops all marks before this sample; then mark the sample's channel.
    always_comb begin
        marks_kept = s_restart_chunk ? '0 : mark_reg;
        mark_next  = mark_reg;
        if (s_accept) begin
            mark_next = marks_kept;
            if (ch_in_range) begin
                mark_next[ch_addr] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= '0;
        end else begin
            mark_reg <= mark_next;
        end
    end

    // History memory: one write and one registered read at the same address.
    always_ff @(posedge aclk) begin
        if (s_accept && ch_in_range) begin
            prev_mem[ch_addr] <= sample_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && ch_in_range) begin
            prev_reg   <= prev_mem[ch_addr];
            sample_reg <= sample_sat;
            first_reg  <= !marks_kept[ch_addr];
        end
    end

    // Absolute value for the first sample of a chunk, else the delta.
    assign diff = first_reg ? DIFF_W'(sample_reg)
                            : DIFF_W'(sample_reg) - DIFF_W'(prev_reg);

    // Clamp to the 35-bit signed range so the code fits five bytes.
    generate
        if (DIFF_W > CODE_W) begin : g_sat_code
            logic code_fits;
            assign code_fits = (&diff[DIFF_W-1:CODE_W-1]) || !(|diff[DIFF_W-1:CODE_W-1]);
            assign code_sat  = code_fits ? diff[CODE_W-1:0] :
                               {diff[DIFF_W-1], {(CODE_W - 1){!diff[DIFF_W-1]}}};
        end else begin : g_ext_code
            assign code_sat = CODE_W'(diff);
        end
    endgenerate

    assign zigzag = {code_sat[CODE_W-2:0], 1'b0} ^ {CODE_W{code_sat[CODE_W-1]}};

    // Any bits left above the low digit mean another byte follows.
    assign more_bytes  = |rest_reg[CODE_W-1:DIG_W];
    assign m_valid     = (state_reg == dzv_pkg::ST_EMIT);
    assign m_code_byte = {more_bytes, rest_reg[DIG_W-1:0]};
    assign m_last_byte = !more_bytes;

    always_comb begin
        state_next = state_reg;
        rest_next  = rest_reg;
        case (state_reg)
            dzv_pkg::ST_IDLE: begin
                if (s_accept && ch_in_range) begin
                    state_next = dzv_pkg::ST_CALC;
                end
            end
            dzv_pkg::ST_CALC: begin
                rest_next  = zigzag;
                state_next = dzv_pkg::ST_EMIT;
            end
            dzv_pkg::ST_EMIT: begin
                if (m_ready) begin
                    if (more_bytes) begin
                        // Advance to the next 7-bit digit.
                        rest_next = rest_reg >> DIG_W;
                    end else if (s_accept && ch_in_range) begin
                        state_next = dzv_pkg::ST_CALC;
                    end else begin
                        state_next = dzv_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = dzv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dzv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rest_reg <= rest_next;
    end

endmodule

// File: rtl/dzv_checker.sv
`include "assert_macros.svh"

module dzv_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic [dzv_pkg::CHANNEL_W-1:0]          s_channel,
    input logic signed [dzv_pkg::SAMPLE_IN_W-1:0] s_sample_centi,
    input logic                                   s_restart_chunk,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [dzv_pkg::BYTE_W-1:0]             m_code_byte,
    input logic                                   m_last_byte
);

    `DZV_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!m_valid && s_ready), "not idle after reset")

    `DZV_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_code_byte) && $stable(m_last_byte)), "stalled output word changed")

    `DZV_ASSERT(a_cont_bit, aclk, aresetn, m_valid |-> (m_code_byte[dzv_pkg::DIGIT_BITS] == !m_last_byte), "continuation bit disagrees with last_byte")

    `DZV_ASSERT(a_next_byte, aclk, aresetn, (m_valid && m_ready && !m_last_byte) |=> m_valid, "gap inside a sample's code")

    `DZV_ASSERT(a_no_overlap, aclk, aresetn, (m_valid && !m_last_byte) |-> !s_ready, "input taken before code finished")

endmodule

bind delta_zigzag_varint_encoder dzv_checker u_dzv_checker (.*);

// File: test/delta_zigzag_varint_encoder_tb.sv
`timescale 1ns / 1ps

module delta_zigzag_varint_encoder_tb;

    localparam int CHANNEL_W   = dzv_pkg::CHANNEL_W;
    localparam int SAMPLE_IN_W = dzv_pkg::SAMPLE_IN_W;
    localparam int BYTE_W      = dzv_pkg::BYTE_W;
    localparam int DIGIT_BITS  = dzv_pkg::DIGIT_BITS;

    localparam int CHANNELS    = 15;
    localparam int SAMPLE_BITS = 32;
    localparam int HALF_PERIOD = 6;
    localparam int MAX_BYTES   = 5;
    localparam int RANDOM_WORDS = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam logic [BYTE_W-1:0] MORE_FLAG = 8'h80;

    // One sample word on the input channel.
    typedef struct packed {
        logic [CHANNEL_W-1:0]          channel;
        logic signed [SAMPLE_IN_W-1:0] sample;
        logic                          restart;
    } sample_word_t;

    // One code byte on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
    } code_byte_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [CHANNEL_W-1:0]          s_channel       = '0;
    logic signed [SAMPLE_IN_W-1:0] s_sample_centi  = '0;
    logic                          s_restart_chunk = 1'b0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [BYTE_W-1:0]             m_code_byte;
    logic                          m_last_byte;

    delta_zigzag_varint_encoder #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel       (s_channel),
        .s_sample_centi  (s_sample_centi),
        .s_restart_chunk (s_restart_chunk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_byte     (m_code_byte),
        .m_last_byte     (m_last_byte)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Words waiting to be offered, and bytes the encoder still owes us.
    sample_word_t pending_words[$];
    code_byte_t   expected_bytes[$];

    // Predictor copy of the per-channel history.
    logic signed [63:0] prev_centi [CHANNELS];
    logic               seen_mark  [CHANNELS] = '{default: 1'b0};

    // Stimulus-side random walk per channel (independent of the predictor).
    logic signed [SAMPLE_IN_W-1:0] walk_centi [16] = '{default: '0};

    int  fail_count     = 0;
    int  words_accepted = 0;
    logic word_taken    = 1'b0;   // s_ handshake seen at the last rising edge
    logic stall_hold    = 1'b0;   // long receiver hold-off in progress

    // Sender burst / gap bookkeeping, owned by the driver block.
    int burst_left = 4;
    int gap_left   = 0;

    // Receiver stall pattern, owned by the ready block.
    logic [7:0] ready_pattern = 8'hFF;
    int         ready_step    = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // Predict the code bytes for one accepted word: restart clears the
    // marks, out-of-range channels emit nothing, the first sample of a chunk
    // goes out absolute and later ones as a delta, ZigZag, then LEB128.
    task automatic encode_sample(input sample_word_t w);
        logic signed [63:0] value;
        logic signed [63:0] delta;
        logic signed [63:0] half;
        logic [63:0]        zz;
        int                 n;
        code_byte_t         b;
        if (w.restart) begin
            foreach (seen_mark[i]) seen_mark[i] = 1'b0;
        end
        if (w.channel >= CHANNELS) return;
        value = w.sample;
        if (SAMPLE_BITS < SAMPLE_IN_W) begin
            half = 64'sd1 <<< (SAMPLE_BITS - 1);
            if (value < -half) value = -half;
            if (value > half - 1) value = half - 1;
        end
        delta = seen_mark[w.channel] ? value - prev_centi[w.channel] : value;
        seen_mark[w.channel]  = 1'b1;
        prev_centi[w.channel] = value;
        // Hold the code to five bytes.
        if (delta < -(64'sd1 <<< 34)) delta = -(64'sd1 <<< 34);
        if (delta > (64'sd1 <<< 34) - 1) delta = (64'sd1 <<< 34) - 1;
        zz = ($unsigned(delta) << 1) ^ ((delta < 0) ? '1 : '0);
        n  = 0;
        while (zz >= 64'(MORE_FLAG) && n < MAX_BYTES - 1) begin
            b.code = BYTE_W'(zz[6:0]) | MORE_FLAG;
            b.last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), b);
            zz = zz >> DIGIT_BITS;
            n++;
        end
        b.code = zz[7:0];
        b.last = 1'b1;
        expected_bytes.insert(expected_bytes.size(), b);
    endtask

    task automatic queue_word(input int ch, input logic signed [31:0] value, input bit restart);
        sample_word_t w;
        w.channel = CHANNEL_W'(ch);
        w.sample  = value;
        w.restart = restart;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Sample the handshakes on the rising edge: predict on every accepted
    // word, then check the byte that leaves against the oldest expectation.
    always @(posedge aclk) begin
        code_byte_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                encode_sample('{channel: s_channel, sample: s_sample_centi,
                                restart: s_restart_chunk});
                words_accepted <= words_accepted + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              m_code_byte, m_last_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_code_byte !== want.code)
                        report_mismatch($sformatf("code_byte got %02h want %02h",
                                                  m_code_byte, want.code));
                    if (m_last_byte !== want.last)
                        report_mismatch($sformatf("last_byte got %0b want %0b",
                                                  m_last_byte, want.last));
                end
            end
        end
    end

    // Drive the input channel on the falling edge. Advance only once the
    // current word has gone (or nothing is offered); hold it otherwise.
    // Work in bursts with random gaps, some of them zero, between them.
    always @(negedge aclk) begin
        sample_word_t w;
        logic         next_valid;
        if (aresetn && (!s_valid || word_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                w               = pending_words.pop_front();
                s_channel       <= w.channel;
                s_sample_centi  <= w.sample;
                s_restart_chunk <= w.restart;
                next_valid      = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            s_valid <= next_valid;
        end
    end

    // Drive m_ready from an 8-bit pattern that is reloaded when ready_step runs out:
    // sometimes always ready, sometimes random, sometimes sparse, sometimes all but one slot.
    always @(negedge aclk) begin
        if (ready_step == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 8'hFF;
                1: ready_pattern = 8'($urandom);
                2: ready_pattern = 8'($urandom) & 8'($urandom);
                default: ready_pattern = ~(8'h01 << $urandom_range(0, 7));
            endcase
            ready_step = 32;
        end
        ready_step--;
        m_ready <= !stall_hold && ready_pattern[ready_step % 8];
    end

    // Hold the receiver off for a long stretch mid-run while the sender keeps
    // offering words, so the encoder backs up and drops s_ready.
    initial begin
        wait (words_accepted >= 60);
        @(negedge aclk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        stall_hold <= 1'b0;
    end

    // Stop a hung run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int ch;
        int in_range;
        logic signed [31:0] value;
        bit restart;

        // Directed words: absolute and delta extremes, every code length,
        // channel edges, the out-of-range channel and restart handling.
        queue_word(0, 0, 1'b1);                  // zero, one byte
        queue_word(0, 32'sh7FFF_FFFF, 1'b0);     // largest positive value, delta from zero
        queue_word(0, 32'sh8000_0000, 1'b0);     // largest negative delta, five bytes
        queue_word(1, -1, 1'b0);                 // first sample negative
        queue_word(1, 32'sh7FFF_FFFF, 1'b0);
        queue_word(14, 63, 1'b0);                // top channel, last one-byte code
        queue_word(14, 127, 1'b0);               // delta 64, first two-byte code
        queue_word(15, 5, 1'b0);                 // out of range, no restart
        queue_word(14, 8191, 1'b0);
        queue_word(15, 7, 1'b1);                 // out of range with restart
        queue_word(14, 64, 1'b0);                // absolute again after the flush
        queue_word(2, 32'sh8000_0000, 1'b0);     // most negative absolute
        queue_word(2, 32'sh8000_0000, 1'b0);     // zero delta
        queue_word(3, 0, 1'b0);
        queue_word(3, 8191, 1'b0);               // largest two-byte delta
        queue_word(3, 16383, 1'b0);              // delta 8192, three bytes
        queue_word(3, 16383 + 1048576, 1'b0);    // four bytes
        queue_word(3, 16383 + 1048576 + 134217728, 1'b0);  // five bytes
        queue_word(4, 32'sh7FFF_FFFF, 1'b0);     // largest positive absolute
        queue_word(4, 100, 1'b1);                // restart on a channel with history
        queue_word(4, 99, 1'b0);                 // small negative delta
        queue_word(5, -64, 1'b0);                // -64 maps to 127
        queue_word(5, -129, 1'b0);

        // Random walk per channel with mostly small steps, some mid-size
        // jumps, full-range values and extremes; restarts and stray channels
        // sprinkled in.
        in_range = 0;
        while (in_range < RANDOM_WORDS) begin
            ch      = ($urandom_range(0, 24) == 0) ? 15 : $urandom_range(0, CHANNELS - 1);
            restart = ($urandom_range(0, 19) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: value = walk_centi[ch] + (int'($urandom_range(0, 200)) - 100);
                5, 6: value = walk_centi[ch] + (int'($urandom_range(0, 1 << 21)) - (1 << 20));
                7, 8: value = $urandom;
                default: begin
                    case ($urandom_range(0, 3))
                        0: value = 32'sh7FFF_FFFF;
                        1: value = 32'sh8000_0000;
                        2: value = 0;
                        default: value = -1;
                    endcase
                end
            endcase
            walk_centi[ch] = value;
            queue_word(ch, value, restart);
            if (ch < CHANNELS) in_range++;
        end

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to go in, every byte to come out, then drain.
        while (pending_words.size() > 0 || s_valid) @(posedge aclk);
        while (expected_bytes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
